### rtl/core/dlm_pkg.sv
// ----------------------------------------------------------------------------
// dlm_pkg
// Shared types, constants and digit arithmetic helpers for the decimal long
// multiplier.
// ----------------------------------------------------------------------------
package dlm_pkg;

   localparam int OPERAND_DIGITS  = 8;
   localparam int PRODUCT_COLUMNS = 16;
   localparam int DIGIT_W         = 4;
   localparam int RADIX           = 10;
   localparam int DIGIT_MAX       = RADIX - 1;
   localparam int OPERAND_W       = 32;
   localparam int PRODUCT_W       = PRODUCT_COLUMNS * DIGIT_W;

   // largest raw column sum and the bounds after each normalizing pass
   localparam int COL_MAX = OPERAND_DIGITS * DIGIT_MAX * DIGIT_MAX;
   localparam int COL_W   = $clog2(COL_MAX + 1);
   localparam int V1_MAX  = DIGIT_MAX + COL_MAX / RADIX;
   localparam int V1_W    = $clog2(V1_MAX + 1);
   localparam int V2_MAX  = DIGIT_MAX + V1_MAX / RADIX;
   localparam int V2_W    = $clog2(V2_MAX + 1);
   localparam int V3_MAX  = DIGIT_MAX + V2_MAX / RADIX;
   localparam int V3_W    = $clog2(V3_MAX + 1);

   // reciprocal for divide by ten, exact for values below 1029
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int DIV10_W     = COL_W + 8;

   typedef logic [PRODUCT_COLUMNS-1:0][COL_W-1:0] col_sum_array_type;

   typedef struct packed {
      logic [OPERAND_W-1:0] multiplicand_digits;
      logic [OPERAND_W-1:0] multiplier_digits;
      logic                 multiplicand_negative;
      logic                 multiplier_negative;
   } dlm_req_type;

   typedef struct packed {
      logic [PRODUCT_W-1:0] product_digits;
      logic                 product_negative;
      logic                 bad_digit;
   } dlm_rsp_type;

   typedef struct packed {
      col_sum_array_type sums;
      logic              product_negative;
      logic              bad_digit;
   } dlm_cols_type;

   function automatic logic [COL_W-1:0] div10(input logic [COL_W-1:0] x);
      logic [DIV10_W-1:0] prod;
      prod = DIV10_W'(x) * DIV10_W'(DIV10_MUL);
      return COL_W'(prod >> DIV10_SHIFT);
   endfunction

   function automatic logic [DIGIT_W-1:0] mod10(input logic [COL_W-1:0] x);
      logic [COL_W-1:0] q;
      q = div10(x);
      return DIGIT_W'(x - COL_W'(q * COL_W'(RADIX)));
   endfunction

endpackage

### rtl/core/dlm_column_sum.sv
// ----------------------------------------------------------------------------
// dlm_column_sum
// Digit-by-digit partial products summed per product column, plus digit
// check and sign of the product.
// ----------------------------------------------------------------------------
module dlm_column_sum (
   input  dlm_pkg::dlm_req_type  req,
   output dlm_pkg::dlm_cols_type cols
);
   import dlm_pkg::*;

   logic [OPERAND_DIGITS-1:0][DIGIT_W-1:0] a_dig;
   logic [OPERAND_DIGITS-1:0][DIGIT_W-1:0] b_dig;
   col_sum_array_type                      sums;
   logic                                   bad;

   always_comb begin
      bad  = 1'b0;
      sums = '0;
      for (int i = 0; i < OPERAND_DIGITS; i++) begin
         a_dig[i] = req.multiplicand_digits[i*DIGIT_W +: DIGIT_W];
         b_dig[i] = req.multiplier_digits[i*DIGIT_W +: DIGIT_W];
         if (a_dig[i] > DIGIT_W'(DIGIT_MAX) || b_dig[i] > DIGIT_W'(DIGIT_MAX)) begin
            bad = 1'b1;
         end
      end
      for (int i = 0; i < OPERAND_DIGITS; i++) begin
         for (int j = 0; j < OPERAND_DIGITS; j++) begin
            sums[i+j] = sums[i+j] + COL_W'(a_dig[i]) * COL_W'(b_dig[j]);
         end
      end
   end

   // product is zero exactly when one magnitude is zero
   assign cols.sums             = sums;
   assign cols.bad_digit        = bad;
   assign cols.product_negative = (req.multiplicand_negative ^ req.multiplier_negative)
                                  & (|a_dig) & (|b_dig) & ~bad;

endmodule

### rtl/core/decimal_long_multiplier.sv
// ----------------------------------------------------------------------------
// decimal_long_multiplier
// Sign-magnitude packed BCD multiplier, eight digits by eight digits into a
// sixteen-digit product, pipelined one operand pair per clock when not stalled.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   dlm_req_type
//   rsp       out         rsp_valid/rsp_stall   dlm_rsp_type
//
// One transfer per clock in each direction when not stalled.
// Pipeline stages in order: input register, column sums, two carry
// normalization stages and the final decimal ripple into the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall on rsp backs up stage by stage; empty stages keep filling.
// ----------------------------------------------------------------------------
module decimal_long_multiplier (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dlm_pkg::dlm_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dlm_pkg::dlm_rsp_type rsp_payload
);
   import dlm_pkg::*;

   // stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, rsp_ready;

   dlm_req_type  s1_req_ff;
   dlm_cols_type s2_cols_in, s2_cols_ff;

   logic [PRODUCT_COLUMNS-1:0][V1_W-1:0] s3_v1_in, s3_v1_ff;
   logic                                 s3_neg_ff, s3_bad_ff;
   logic [PRODUCT_COLUMNS-1:0][V2_W-1:0] s4_v2;
   logic [PRODUCT_COLUMNS-1:0][V3_W-1:0] s4_v3_in, s4_v3_ff;
   logic                                 s4_neg_ff, s4_bad_ff;

   logic [PRODUCT_COLUMNS:0]             ripple_carry;
   logic [V3_W-1:0]                      ripple_sum;
   logic [PRODUCT_W-1:0]                 product_in;
   dlm_rsp_type                          rsp_payload_in, rsp_payload_ff;

   assign rsp_ready = ~rsp_valid_ff | ~rsp_stall;
   assign s4_ready  = ~s4_valid_ff | rsp_ready;
   assign s3_ready  = ~s3_valid_ff | s4_ready;
   assign s2_ready  = ~s2_valid_ff | s3_ready;
   assign s1_ready  = ~s1_valid_ff | s2_ready;
   assign req_stall = ~s1_ready;

   dlm_column_sum u_column_sum (
      .req  (s1_req_ff),
      .cols (s2_cols_in)
   );

   // first pass: split each raw column sum into digit and carry
   always_comb begin
      for (int c = 0; c < PRODUCT_COLUMNS; c++) begin
         s3_v1_in[c] = V1_W'(mod10(s2_cols_ff.sums[c]));
         if (c > 0) begin
            s3_v1_in[c] = s3_v1_in[c] + V1_W'(div10(s2_cols_ff.sums[c-1]));
         end
      end
   end

   // second and third passes on narrow values, columns end up at ten or below
   always_comb begin
      for (int c = 0; c < PRODUCT_COLUMNS; c++) begin
         s4_v2[c] = V2_W'(mod10(COL_W'(s3_v1_ff[c])));
         if (c > 0) begin
            s4_v2[c] = s4_v2[c] + V2_W'(div10(COL_W'(s3_v1_ff[c-1])));
         end
      end
      for (int c = 0; c < PRODUCT_COLUMNS; c++) begin
         s4_v3_in[c] = V3_W'(mod10(COL_W'(s4_v2[c])));
         if (c > 0) begin
            s4_v3_in[c] = s4_v3_in[c] + V3_W'(div10(COL_W'(s4_v2[c-1])));
         end
      end
   end

   // final decimal ripple: a column of ten generates, a column of nine passes
   always_comb begin
      ripple_carry[0] = 1'b0;
      ripple_sum      = '0;
      product_in      = '0;
      for (int c = 0; c < PRODUCT_COLUMNS; c++) begin
         ripple_carry[c+1] = (s4_v3_ff[c] == V3_W'(RADIX))
                             | ((s4_v3_ff[c] == V3_W'(DIGIT_MAX)) & ripple_carry[c]);
         ripple_sum = s4_v3_ff[c] + V3_W'(ripple_carry[c]);
         if (ripple_sum >= V3_W'(RADIX)) begin
            ripple_sum = ripple_sum - V3_W'(RADIX);
         end
         product_in[c*DIGIT_W +: DIGIT_W] = DIGIT_W'(ripple_sum);
      end
      rsp_payload_in.product_digits   = s4_bad_ff ? '0 : product_in;
      rsp_payload_in.product_negative = s4_neg_ff & ~s4_bad_ff;
      rsp_payload_in.bad_digit        = s4_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_req_ff <= req_payload;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_cols_ff <= s2_cols_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_v1_ff  <= s3_v1_in;
         s3_neg_ff <= s2_cols_ff.product_negative;
         s3_bad_ff <= s2_cols_ff.bad_digit;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_v3_ff  <= s4_v3_in;
         s4_neg_ff <= s3_neg_ff;
         s4_bad_ff <= s3_bad_ff;
      end
      if (rsp_ready && s4_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### rtl/core/dlm_checker.sv
// ----------------------------------------------------------------------------
// dlm_checker
// Port-level checks for the decimal long multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module dlm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input dlm_pkg::dlm_rsp_type rsp_payload
);
   import dlm_pkg::*;

   logic digits_ok;

   always_comb begin
      digits_ok = 1'b1;
      for (int c = 0; c < PRODUCT_COLUMNS; c++) begin
         if (rsp_payload.product_digits[c*DIGIT_W +: DIGIT_W] > DIGIT_W'(DIGIT_MAX)) begin
            digits_ok = 1'b0;
         end
      end
   end

   // stalled transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_digit |->
         rsp_payload.product_digits == '0 && !rsp_payload.product_negative)
      else $error("bad digit result not cleared");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.product_negative |-> rsp_payload.product_digits != '0)
      else $error("negative sign on zero product");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> digits_ok)
      else $error("product digit above nine");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind decimal_long_multiplier dlm_checker u_dlm_checker (.*);
